@@ hdl/bmp_rle4_row_encoder_defines.svh @@
// Assertion macros for the BMP RLE4 row encoder checker.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef BMP_RLE4_ROW_ENCODER_DEFINES_SVH
`define BMP_RLE4_ROW_ENCODER_DEFINES_SVH

// Check a property outside reset.
`define BRE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property that also covers reset.
`define BRE_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ hdl/bre_pkg.sv @@
// Shared constants, codes and controller/datapath types for the RLE4 encoder.
// No dependencies.
package bre_pkg;

    localparam int MAX_SEGMENT = 255;
    localparam int CNT_W       = $clog2(MAX_SEGMENT + 1);
    localparam int ADDR_W      = $clog2(MAX_SEGMENT);
    localparam int PIX_W       = 4;
    localparam int BYTE_W      = 8;
    localparam int GROUP_BYTES = 4;
    localparam int GROUP_W     = GROUP_BYTES * BYTE_W;
    localparam int BCNT_W      = 3;
    localparam int SLOT_W      = 2;

    localparam logic [BYTE_W-1:0] ESC_BYTE = 8'h00;
    localparam logic [BYTE_W-1:0] EOL_BYTE = 8'h00;
    localparam logic [BYTE_W-1:0] EOB_BYTE = 8'h01;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_START,
        OP_APPEND,
        OP_ABS_APPEND,
        OP_CLEAR
    } t_dp_op;

    typedef enum logic [2:0] {
        SEL_ESC,
        SEL_CNT,
        SEL_ENC,
        SEL_ABS,
        SEL_EOL,
        SEL_EOB
    } t_byte_sel;

    typedef enum logic [1:0] {
        POST_NONE,
        POST_START,
        POST_CLEAR
    } t_post;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_ENC0,
        S_ENC1,
        S_ABS0,
        S_ABS1,
        S_ABSLO,
        S_ABSBYTE,
        S_ABSPAD,
        S_POST,
        S_ROW,
        S_EOL0,
        S_EOL1,
        S_EOB0,
        S_EOB1
    } t_state;

    typedef struct packed {
        t_dp_op    op;
        logic      rd_first;
        logic      rd_next;
        logic      hi_latch;
        t_byte_sel sel;
        logic      byte_valid;
        logic      byte_last;
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic is_abs;
        logic match0;
        logic triple;
        logic cnt_ge3;
        logic cap_next;
        logic rd_more;
        logic pad;
        logic row;
        logic img;
    } t_dp_stat;

endpackage

@@ hdl/bre_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bre_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 255
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/bre_dp.sv @@
// Datapath: segment state, pending pixel store and stream byte selection.
// Depends on bre_pkg and bre_ram.
module bre_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [bre_pkg::PIX_W-1:0]  i_pixel,
    input  logic                       i_row_end,
    input  logic                       i_image_end,
    input  bre_pkg::t_dp_cmd           i_cmd,
    output bre_pkg::t_dp_stat          o_stat,
    output logic [bre_pkg::BYTE_W-1:0] o_byte
);
    import bre_pkg::*;

    logic [CNT_W-1:0]  r_cnt;
    logic              r_abs;
    logic [PIX_W-1:0]  r_pix0;
    logic [PIX_W-1:0]  r_prev1;
    logic [PIX_W-1:0]  r_prev2;
    logic [PIX_W-1:0]  r_px;
    logic              r_row;
    logic              r_img;
    logic [CNT_W-1:0]  r_idx;
    logic [PIX_W-1:0]  r_hi;
    logic              r_lo_ok;

    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic              w_re;
    logic [ADDR_W-1:0] w_raddr;
    logic [PIX_W-1:0]  w_q;
    logic [CNT_W:0]    w_np1;
    logic              w_rd_more;

    assign w_we    = (i_cmd.op == OP_START) || (i_cmd.op == OP_APPEND)
                  || (i_cmd.op == OP_ABS_APPEND);
    assign w_waddr = (i_cmd.op == OP_START) ? '0 : r_cnt[ADDR_W-1:0];
    assign w_re    = i_cmd.rd_first || i_cmd.rd_next;
    assign w_raddr = i_cmd.rd_first ? '0 : r_idx[ADDR_W-1:0];

    bre_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_SEGMENT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_px),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_q)
    );

    assign w_np1     = {1'b0, r_cnt} + (CNT_W+1)'(1);
    assign w_rd_more = r_idx < r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_abs <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                OP_START: begin
                    r_cnt <= CNT_W'(1);
                    r_abs <= 1'b0;
                end
                OP_APPEND: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
                OP_ABS_APPEND: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    r_abs <= 1'b1;
                end
                OP_CLEAR: begin
                    r_cnt <= '0;
                    r_abs <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            r_px  <= i_pixel;
            r_row <= i_row_end | i_image_end;
            r_img <= i_image_end;
        end
        if (i_cmd.op == OP_START) begin
            r_pix0  <= r_px;
            r_prev1 <= r_px;
        end
        if ((i_cmd.op == OP_APPEND) || (i_cmd.op == OP_ABS_APPEND)) begin
            r_prev2 <= r_prev1;
            r_prev1 <= r_px;
        end
        if (i_cmd.rd_first) begin
            r_idx <= CNT_W'(1);
        end else if (i_cmd.rd_next) begin
            r_idx <= r_idx + CNT_W'(1);
        end
        if (i_cmd.hi_latch) begin
            r_hi    <= w_q;
            r_lo_ok <= w_rd_more;
        end
    end

    always_comb begin
        unique case (i_cmd.sel)
            SEL_ESC: o_byte = ESC_BYTE;
            SEL_CNT: o_byte = BYTE_W'(r_cnt);
            SEL_ENC: o_byte = {r_pix0, (r_cnt == CNT_W'(1)) ? {PIX_W{1'b0}} : r_prev1};
            SEL_ABS: o_byte = {r_hi, r_lo_ok ? w_q : {PIX_W{1'b0}}};
            SEL_EOL: o_byte = EOL_BYTE;
            SEL_EOB: o_byte = EOB_BYTE;
            default: o_byte = ESC_BYTE;
        endcase
    end

    assign o_stat.cnt_zero = (r_cnt == '0);
    assign o_stat.is_abs   = r_abs;
    assign o_stat.match0   = (r_px == r_pix0);
    assign o_stat.triple   = (r_cnt >= CNT_W'(2)) && (r_px == r_prev1) && (r_px == r_prev2);
    assign o_stat.cnt_ge3  = (r_cnt >= CNT_W'(3));
    assign o_stat.cap_next = (r_cnt == CNT_W'(MAX_SEGMENT - 1));
    assign o_stat.rd_more  = w_rd_more;
    assign o_stat.pad      = w_np1[1];
    assign o_stat.row      = r_row;
    assign o_stat.img      = r_img;

endmodule

@@ hdl/bre_pack.sv @@
// Byte packer: gathers stream bytes into four-byte groups and holds the output register.
// Depends on bre_pkg.
module bre_pack (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_byte_valid,
    input  logic [bre_pkg::BYTE_W-1:0]  i_byte,
    input  logic                        i_byte_last,
    output logic                        o_byte_ready,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [bre_pkg::GROUP_W-1:0] o_byte_group,
    output logic [bre_pkg::BCNT_W-1:0]  o_byte_count,
    output logic                        o_last_of_run
);
    import bre_pkg::*;

    logic [GROUP_W-1:0] r_acc;
    logic [SLOT_W-1:0]  r_n;
    logic               r_ovalid;
    logic [GROUP_W-1:0] r_group;
    logic [BCNT_W-1:0]  r_count;
    logic               r_last;

    logic               w_push;
    logic               w_out_free;
    logic               w_fire;
    logic [GROUP_W-1:0] w_word;

    assign w_push       = i_byte_last || (r_n == SLOT_W'(GROUP_BYTES - 1));
    assign w_out_free   = !r_ovalid || !i_stall;
    assign o_byte_ready = !w_push || w_out_free;
    assign w_fire       = i_byte_valid && o_byte_ready;
    assign w_word       = r_acc | (GROUP_W'(i_byte)
                          << (BYTE_W * (GROUP_BYTES - 1 - int'(r_n))));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_n      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (w_fire) begin
                if (w_push) begin
                    r_ovalid <= 1'b1;
                    r_acc    <= '0;
                    r_n      <= '0;
                end else begin
                    r_acc <= w_word;
                    r_n   <= r_n + SLOT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_push) begin
            r_group <= w_word;
            r_count <= BCNT_W'(r_n) + BCNT_W'(1);
            r_last  <= i_byte_last;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_byte_group  = r_group;
    assign o_byte_count  = r_count;
    assign o_last_of_run = r_last;

endmodule

@@ hdl/bre_ctrl.sv @@
// Controller: sequences segment decisions, encoded pairs, absolute segments and end codes.
// Depends on bre_pkg.
module bre_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_in_stall,
    input  bre_pkg::t_dp_stat  i_stat,
    input  logic               i_byte_ready,
    output bre_pkg::t_dp_cmd   o_cmd
);
    import bre_pkg::*;

    t_state r_state, n_state;
    t_post  r_post, n_post;
    logic   r_flush, n_flush;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_post  <= POST_NONE;
            r_flush <= 1'b0;
        end else begin
            r_state <= n_state;
            r_post  <= n_post;
            r_flush <= n_flush;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_post     = r_post;
        n_flush    = r_flush;
        o_in_stall = 1'b1;
        o_cmd      = '{op: OP_NONE, rd_first: 1'b0, rd_next: 1'b0, hi_latch: 1'b0,
                       sel: SEL_ESC, byte_valid: 1'b0, byte_last: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_flush = 1'b0;
                n_state = i_stat.row ? S_ROW : S_IDLE;
                priority if (i_stat.cnt_zero) begin
                    o_cmd.op = OP_START;
                end else if (!i_stat.is_abs) begin
                    priority if (i_stat.match0) begin
                        o_cmd.op = OP_APPEND;
                        if (i_stat.cap_next) begin
                            n_post  = POST_CLEAR;
                            n_state = S_ENC0;
                        end
                    end else if (i_stat.cnt_ge3) begin
                        n_post  = POST_START;
                        n_state = S_ENC0;
                    end else begin
                        o_cmd.op = OP_ABS_APPEND;
                    end
                end else if (i_stat.triple) begin
                    n_post  = POST_START;
                    n_state = S_ABS0;
                end else begin
                    o_cmd.op = OP_APPEND;
                    if (i_stat.cap_next) begin
                        n_post  = POST_CLEAR;
                        n_state = S_ABS0;
                    end
                end
            end
            S_ENC0: begin
                o_cmd.byte_valid = 1'b1;
                o_cmd.sel        = SEL_CNT;
                if (i_byte_ready) begin
                    n_state = S_ENC1;
                end
            end
            S_ENC1: begin
                o_cmd.byte_valid = 1'b1;
                o_cmd.sel        = SEL_ENC;
                o_cmd.byte_last  = !i_stat.row;
                if (i_byte_ready) begin
                    n_state = S_POST;
                end
            end
            S_ABS0: begin
                o_cmd.byte_valid = 1'b1;
                o_cmd.sel        = SEL_ESC;
                if (i_byte_ready) begin
                    n_state = S_ABS1;
                end
            end
            S_ABS1: begin
                o_cmd.byte_valid = 1'b1;
                o_cmd.sel        = SEL_CNT;
                if (i_byte_ready) begin
                    o_cmd.rd_first = 1'b1;
                    n_state        = S_ABSLO;
                end
            end
            S_ABSLO: begin
                o_cmd.hi_latch = 1'b1;
                o_cmd.rd_next  = i_stat.rd_more;
                n_state        = S_ABSBYTE;
            end
            S_ABSBYTE: begin
                o_cmd.byte_valid = 1'b1;
                o_cmd.sel        = SEL_ABS;
                o_cmd.byte_last  = !i_stat.row && !i_stat.rd_more && !i_stat.pad;
                if (i_byte_ready) begin
                    priority if (i_stat.rd_more) begin
                        o_cmd.rd_next = 1'b1;
                        n_state       = S_ABSLO;
                    end else if (i_stat.pad) begin
                        n_state = S_ABSPAD;
                    end else begin
                        n_state = S_POST;
                    end
                end
            end
            S_ABSPAD: begin
                o_cmd.byte_valid = 1'b1;
                o_cmd.sel        = SEL_ESC;
                o_cmd.byte_last  = !i_stat.row;
                if (i_byte_ready) begin
                    n_state = S_POST;
                end
            end
            S_POST: begin
                unique case (r_post)
                    POST_START: o_cmd.op = OP_START;
                    POST_CLEAR: o_cmd.op = OP_CLEAR;
                    default:    o_cmd.op = OP_NONE;
                endcase
                n_post = POST_NONE;
                priority if (r_flush) begin
                    n_state = S_EOL0;
                end else if (i_stat.row) begin
                    n_state = S_ROW;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ROW: begin
                n_flush = 1'b1;
                n_post  = POST_CLEAR;
                priority if (i_stat.cnt_zero) begin
                    n_state = S_EOL0;
                end else if (i_stat.is_abs && i_stat.cnt_ge3) begin
                    n_state = S_ABS0;
                end else begin
                    n_state = S_ENC0;
                end
            end
            S_EOL0: begin
                o_cmd.byte_valid = 1'b1;
                o_cmd.sel        = SEL_ESC;
                if (i_byte_ready) begin
                    n_state = S_EOL1;
                end
            end
            S_EOL1: begin
                o_cmd.byte_valid = 1'b1;
                o_cmd.sel        = SEL_EOL;
                o_cmd.byte_last  = !i_stat.img;
                n_post           = POST_NONE;
                if (i_byte_ready) begin
                    n_state = i_stat.img ? S_EOB0 : S_IDLE;
                end
            end
            S_EOB0: begin
                o_cmd.byte_valid = 1'b1;
                o_cmd.sel        = SEL_ESC;
                if (i_byte_ready) begin
                    n_state = S_EOB1;
                end
            end
            S_EOB1: begin
                o_cmd.byte_valid = 1'b1;
                o_cmd.sel        = SEL_EOB;
                o_cmd.byte_last  = 1'b1;
                if (i_byte_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/bmp_rle4_row_encoder.sv @@
// BMP RLE4 row encoder: 4-bit pixels in, RLE4 byte stream out in groups of four bytes.
// Depends on bre_pkg, bre_ctrl, bre_dp and bre_pack.
//
// One pixel is taken at a time; o_stall stays high until every byte it causes has
// been handed to the packer. A pixel that causes no bytes is taken, then decided on.
// Each byte of an encoded pair or an end code has a state of its own, and so do the
// escape, length and pad bytes of an absolute segment. Each packed byte of an absolute
// segment passes through S_ABSLO and S_ABSBYTE (one pending-pixel store read port, one
// pixel per read). A finished segment passes through S_POST to update the segment
// state, and a row end through S_ROW to choose how to flush. A byte that completes a
// group and finds the output register full waits until the receiver takes the group.
// The output register lets the next pixel in while the last group waits.
module bmp_rle4_row_encoder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [bre_pkg::PIX_W-1:0]   i_pixel,
    input  logic                        i_row_end,
    input  logic                        i_image_end,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [bre_pkg::GROUP_W-1:0] o_byte_group,
    output logic [bre_pkg::BCNT_W-1:0]  o_byte_count,
    output logic                        o_last_of_run
);
    import bre_pkg::*;

    t_dp_cmd            w_cmd;
    t_dp_stat           w_stat;
    logic [BYTE_W-1:0]  w_byte;
    logic               w_byte_ready;

    bre_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_in_stall   (o_stall),
        .i_stat       (w_stat),
        .i_byte_ready (w_byte_ready),
        .o_cmd        (w_cmd)
    );

    bre_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pixel     (i_pixel),
        .i_row_end   (i_row_end),
        .i_image_end (i_image_end),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_byte      (w_byte)
    );

    bre_pack u_pack (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_byte_valid  (w_cmd.byte_valid),
        .i_byte        (w_byte),
        .i_byte_last   (w_cmd.byte_last),
        .o_byte_ready  (w_byte_ready),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_byte_group  (o_byte_group),
        .o_byte_count  (o_byte_count),
        .o_last_of_run (o_last_of_run)
    );

endmodule

@@ hdl/bre_chk.sv @@
// Port-level checker for the RLE4 encoder output channel, bound to the top level.
// Depends on bre_pkg and bmp_rle4_row_encoder_defines.svh.
`include "bmp_rle4_row_encoder_defines.svh"

module bre_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [bre_pkg::GROUP_W-1:0] o_byte_group,
    input logic [bre_pkg::BCNT_W-1:0]  o_byte_count,
    input logic                        o_last_of_run
);
    import bre_pkg::*;

    `BRE_ASSERT_RST(a_rst_clears, !i_rst_n |=> !o_valid, "output valid after reset")
    `BRE_ASSERT(a_hold, o_valid && i_stall |=> o_valid, "stalled item dropped")
    `BRE_ASSERT(a_count, o_valid |-> o_byte_count != 3'd0 && o_byte_count <= 3'd4, "bad count")
    `BRE_ASSERT(a_full, o_valid && !o_last_of_run |-> o_byte_count == 3'd4, "short group not last")
    `BRE_ASSERT(a_zero, o_valid && o_byte_count == 3'd1 |-> o_byte_group[23:0] == 24'd0, "stray bytes")

endmodule

bind bmp_rle4_row_encoder bre_chk u_chk (.*);

@@ sim/tb_bmp_rle4_row_encoder.sv @@
// Testbench for the BMP RLE4 row encoder: a directed table, a 256-pixel row, then random rows.
// Depends on bre_pkg and bmp_rle4_row_encoder; each output group is checked against a predictor.
`timescale 1ns / 100ps

module tb_bmp_rle4_row_encoder;
    import bre_pkg::*;

    typedef struct packed {
        logic [GROUP_W-1:0] group;
        logic [BCNT_W-1:0]  count;
        logic               last;
    } t_group;

    typedef struct {
        logic [PIX_W-1:0]   pixel;
        logic               row_end;
        logic               image_end;
        logic               has_exp;
        logic [GROUP_W-1:0] exp_group;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [PIX_W-1:0]     i_pixel;
    logic                 i_row_end;
    logic                 i_image_end;
    logic                 o_valid;
    logic                 i_stall;
    logic [GROUP_W-1:0]   o_byte_group;
    logic [BCNT_W-1:0]    o_byte_count;
    logic                 o_last_of_run;

    bmp_rle4_row_encoder dut (.*);

    logic [PIX_W-1:0] seg_pix [MAX_SEGMENT];
    int               seg_cnt;
    int               lead_len;
    logic             seg_abs;
    logic [7:0]       byte_buf [$];
    t_group           exp_groups [$];
    t_group           pred_first;
    int               errors;
    int               hold_off;
    t_row             directed [$];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("tb_bmp_rle4_row_encoder: errors");
        $finish;
    end

    function automatic logic [3:0] seg_at(int k);
        return (k < MAX_SEGMENT) ? seg_pix[k] : 4'h0;
    endfunction

    task automatic put_byte(logic [7:0] v);
        byte_buf = {byte_buf, v};
    endtask

    task automatic put_run(int n, logic [3:0] p);
        put_byte(n[7:0]);
        put_byte({p, p});
    endtask

    task automatic put_absolute(int len);
        int j;
        put_byte(ESC_BYTE);
        put_byte(len[7:0]);
        for (j = 0; j < len; j += 2)
            put_byte({seg_at(j), (j + 1 < len) ? seg_at(j + 1) : 4'h0});
        if ((((len + 1) / 2) & 1) != 0)
            put_byte(8'h00);
    endtask

    task automatic open_segment(logic [3:0] p);
        seg_pix[0] = p;
        seg_cnt = 1;
        lead_len = 1;
        seg_abs = 1'b0;
    endtask

    task automatic add_pixel(logic [3:0] p);
        if (seg_cnt < MAX_SEGMENT) begin
            seg_pix[seg_cnt] = p;
            seg_cnt++;
        end
    endtask

    task automatic cap_segment();
        if (seg_cnt >= MAX_SEGMENT) begin
            if (seg_abs) put_absolute(seg_cnt);
            else put_run(seg_cnt, seg_at(0));
            seg_cnt = 0;
            lead_len = 0;
            seg_abs = 1'b0;
        end
    endtask

    task automatic predict_pixel(logic [3:0] p, logic re, logic ie);
        int k;
        int b;
        t_group g;
        byte_buf.delete();
        pred_first = '0;
        if (seg_cnt == 0) begin
            open_segment(p);
        end else if (!seg_abs) begin
            if (p == seg_at(0)) begin
                add_pixel(p);
                lead_len = seg_cnt;
            end else if (lead_len >= 3) begin
                put_run(lead_len, seg_at(0));
                open_segment(p);
            end else begin
                seg_abs = 1'b1;
                add_pixel(p);
            end
            cap_segment();
        end else begin
            if (seg_cnt >= 2 && p == seg_at(seg_cnt - 1) && p == seg_at(seg_cnt - 2)) begin
                put_absolute(seg_cnt);
                open_segment(p);
            end else begin
                add_pixel(p);
            end
            cap_segment();
        end
        if (re || ie) begin
            if (seg_cnt != 0 && seg_cnt < 3) begin
                put_byte(seg_cnt[7:0]);
                put_byte({seg_at(0), (seg_cnt == 2) ? seg_at(1) : 4'h0});
            end else if (seg_cnt >= 3 && seg_abs) begin
                put_absolute(seg_cnt);
            end else if (seg_cnt >= 3) begin
                put_run(seg_cnt, seg_at(0));
            end
            seg_cnt = 0;
            lead_len = 0;
            seg_abs = 1'b0;
            put_byte(EOL_BYTE);
            put_byte(EOL_BYTE);
            if (ie) begin
                put_byte(ESC_BYTE);
                put_byte(EOB_BYTE);
            end
        end
        for (k = 0; k < byte_buf.size(); k += 4) begin
            g = '0;
            g.count = (byte_buf.size() - k < 4) ? BCNT_W'(byte_buf.size() - k) : BCNT_W'(4);
            for (b = 0; b < g.count; b++)
                g.group[31 - 8 * b -: 8] = byte_buf[k + b];
            g.last = (k + 4 >= byte_buf.size());
            if (k == 0) pred_first = g;
            exp_groups = {exp_groups, g};
        end
    endtask

    task automatic send_pixel(logic [3:0] p, logic re, logic ie);
        int gap;
        gap = $urandom_range(0, 17);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= p;
        i_row_end <= re;
        i_image_end <= ie;
        predict_pixel(p, re, ie);
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic stop_input();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic add_row(logic [3:0] p, logic re, logic ie, logic he, logic [31:0] eg);
        t_row r;
        r.pixel = p;
        r.row_end = re;
        r.image_end = ie;
        r.has_exp = he;
        r.exp_group = eg;
        directed = {directed, r};
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (exp_groups.size() == 0) begin
                $display("%0t unexpected group: actual %h/%0d", $time, o_byte_group,
                         o_byte_count);
                errors++;
            end else if (o_byte_group !== exp_groups[0].group
                         || o_byte_count !== exp_groups[0].count
                         || o_last_of_run !== exp_groups[0].last) begin
                $display("%0t mismatch: expected %h/%0d/%b actual %h/%0d/%b", $time,
                         exp_groups[0].group, exp_groups[0].count, exp_groups[0].last,
                         o_byte_group, o_byte_count, o_last_of_run);
                errors++;
                void'(exp_groups.pop_front());
            end else begin
                void'(exp_groups.pop_front());
            end
        end
    end

    initial begin
        int gap;
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_off > 0) begin
                i_stall <= 1'b1;
                repeat (hold_off) @(posedge i_clk);
                hold_off = 0;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    initial begin
        int n;
        int i;
        int len;
        int mode;
        logic [3:0] p;
        errors = 0;
        hold_off = 0;
        seg_cnt = 0;
        lead_len = 0;
        seg_abs = 1'b0;
        pred_first = '0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_pixel = '0;
        i_row_end = 1'b0;
        i_image_end = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row(4'hF, 1'b1, 1'b0, 1'b1, 32'h01F0_0000);
        add_row(4'h0, 1'b0, 1'b1, 1'b1, 32'h0100_0000);
        add_row(4'h3, 1'b0, 1'b0, 1'b0, '0);
        add_row(4'hA, 1'b1, 1'b0, 1'b1, 32'h023A_0000);
        add_row(4'h5, 1'b0, 1'b0, 1'b0, '0);
        add_row(4'h5, 1'b0, 1'b0, 1'b0, '0);
        add_row(4'h5, 1'b0, 1'b0, 1'b0, '0);
        add_row(4'h5, 1'b0, 1'b0, 1'b0, '0);
        add_row(4'h9, 1'b0, 1'b0, 1'b0, '0);
        add_row(4'h1, 1'b0, 1'b0, 1'b0, '0);
        add_row(4'h2, 1'b0, 1'b0, 1'b0, '0);
        add_row(4'h2, 1'b0, 1'b0, 1'b0, '0);
        add_row(4'h2, 1'b0, 1'b0, 1'b0, '0);
        add_row(4'hC, 1'b0, 1'b0, 1'b0, '0);
        add_row(4'h7, 1'b0, 1'b0, 1'b0, '0);
        add_row(4'hE, 1'b0, 1'b0, 1'b0, '0);
        add_row(4'h6, 1'b1, 1'b1, 1'b0, '0);
        foreach (directed[k]) begin
            send_pixel(directed[k].pixel, directed[k].row_end, directed[k].image_end);
            if (directed[k].has_exp && pred_first.group !== directed[k].exp_group) begin
                $display("%0t directed mismatch: expected %h actual prediction %h",
                         $time, directed[k].exp_group, pred_first.group);
                errors++;
            end
        end

        for (i = 0; i < 256; i++)
            send_pixel(i[3:0] ^ i[7:4], i == 255, 1'b0);
        stop_input();
        while (exp_groups.size() != 0) @(posedge i_clk);

        hold_off = 300;
        n = 0;
        while (n < 200) begin
            mode = $urandom_range(0, 9);
            len = $urandom_range(1, 24);
            p = 4'($urandom_range(0, 15));
            for (i = 0; i < len && n < 200; i++) begin
                if (mode < 4) begin
                    if ($urandom_range(0, 3) == 0) p = 4'($urandom_range(0, 15));
                end else if (mode < 8) begin
                    p = 4'($urandom_range(0, 15));
                end else begin
                    p = $urandom_range(0, 1) ? p : 4'($urandom_range(0, 15));
                end
                send_pixel(p, i == len - 1, (i == len - 1) && $urandom_range(0, 7) == 0);
                n++;
            end
            if (n > 90 && n < 120) begin
                stop_input();
                while (exp_groups.size() != 0) @(posedge i_clk);
            end
        end

        stop_input();
        while (exp_groups.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && exp_groups.size() == 0) begin
            $display("tb_bmp_rle4_row_encoder: clean");
        end else begin
            $display("tb_bmp_rle4_row_encoder: errors");
        end
        $finish;
    end
endmodule
